/* hdl/wav_chunk_stream_parser_defines.svh */
// assertion macros for the wav chunk stream parser
`ifndef WAV_CHUNK_STREAM_PARSER_DEFINES_SVH
`define WAV_CHUNK_STREAM_PARSER_DEFINES_SVH

// condition checked at every rising clock edge outside reset
`define WCSP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wcsp check failed");

// implication checked at every rising clock edge outside reset
`define WCSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wcsp check failed");

`endif

/* hdl/wcsp_pkg.sv */
// types and constants for the wav chunk stream parser
`timescale 1ns / 1ps

package wcsp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM = 16'd1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_ID    = 4'd3,
        PH_SIZE  = 4'd4,
        PH_FMT   = 4'd5,
        PH_EXT   = 4'd6,
        PH_DATA  = 4'd7,
        PH_SKIP  = 4'd8,
        PH_WAIT  = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_FORMAT  = 2'd1,
        EV_DONE    = 2'd2,
        EV_ERROR   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ERR_INVALID     = 2'd0,
        ERR_UNSUPPORTED = 2'd1,
        ERR_TRUNCATED   = 2'd2
    } t_err;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] fmt_code;
        logic [15:0] chan_count;
        logic [31:0] samp_rate;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [31:0] payload_len;
        t_err        error_code;
    } t_result;

    function automatic t_result f_payload(input logic [7:0] b, input logic last);
        t_result r;
        r = '0;
        r.event_res = EV_PAYLOAD;
        r.payload_byte = b;
        r.last_payload = last;
        return r;
    endfunction

    function automatic t_result f_format(input t_event ev, input logic [127:0] fmt,
                                         input logic [31:0] dsize);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.fmt_code = fmt[15:0];
        r.chan_count = fmt[31:16];
        r.samp_rate = fmt[63:32];
        r.bytes_per_sec = fmt[95:64];
        r.frame_bytes = fmt[111:96];
        r.sample_bits = fmt[127:112];
        r.payload_len = dsize;
        return r;
    endfunction

    function automatic t_result f_error(input t_err code);
        t_result r;
        r = '0;
        r.event_res = EV_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

/* hdl/wav_chunk_stream_parser.sv */
// Byte-serial RIFF/WAVE parser: takes one file byte per transfer, checks the RIFF and
// WAVE magics, walks the chunks and reports the captured fmt fields, each data byte,
// parse completion and errors as result transfers. One byte is taken every cycle while
// o_stall is low; a byte that causes two results (fmt done with completion, the last data
// byte with completion or an early end) writes both into the queue at once. Results go through a
// four-entry output queue, and o_stall rises when fewer than two entries are free, so
// the input rate is set by how fast the downstream side takes results.
`timescale 1ns / 1ps
`include "wav_chunk_stream_parser_defines.svh"

module wav_chunk_stream_parser
    import wcsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_payload,
    output logic [15:0] o_fmt_code,
    output logic [15:0] o_chan_count,
    output logic [31:0] o_samp_rate,
    output logic [31:0] o_bytes_per_sec,
    output logic [15:0] o_frame_bytes,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_payload_len,
    output logic [1:0]  o_error_code
);

    t_phase         r_phase, n_phase;
    logic [31:0]    r_pos, n_pos;
    logic [31:0]    r_tag, n_tag;
    logic [31:0]    r_len, n_len;
    logic [127:0]   r_fmt, n_fmt;
    logic [31:0]    r_dsize, n_dsize;
    logic           r_fseen, n_fseen;
    logic           r_dseen, n_dseen;

    t_result        r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_cnt;

    t_result        w_res [2];
    logic [1:0]     w_push;
    logic           w_accept;
    logic           w_pop;
    t_result        w_head;

    assign o_stall  = (r_cnt > Q_CW'(Q_DEPTH - 2));
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = (r_cnt != '0);
    assign w_pop    = o_valid && !i_stall;
    assign w_head   = r_q[r_rd];

    always_comb begin
        logic [31:0] pos_inc;
        logic        last;
        logic        fin;
        pos_inc = r_pos + 32'd1;
        last    = 1'b0;
        fin     = 1'b0;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_tag   = r_tag;
        n_len   = r_len;
        n_fmt   = r_fmt;
        n_dsize = r_dsize;
        n_fseen = r_fseen;
        n_dseen = r_dseen;
        w_res[0] = '0;
        w_res[1] = '0;
        w_push  = 2'd0;
        if (w_accept) begin
            unique case (r_phase)
                PH_RIFF, PH_WAVE, PH_ID: begin
                    n_tag = {i_data_byte, r_tag[31:8]};
                    n_pos = pos_inc;
                    if (pos_inc == 32'd4) begin
                        n_pos = '0;
                        if (r_phase == PH_RIFF) begin
                            if (n_tag != TAG_RIFF) begin
                                w_res[w_push[0]] = f_error(ERR_INVALID);
                                w_push = w_push + 2'd1;
                                n_phase = PH_WAIT;
                            end else begin
                                n_phase = PH_RSIZE;
                            end
                        end else if (r_phase == PH_WAVE) begin
                            if (n_tag != TAG_WAVE) begin
                                w_res[w_push[0]] = f_error(ERR_INVALID);
                                w_push = w_push + 2'd1;
                                n_phase = PH_WAIT;
                            end else begin
                                n_phase = PH_ID;
                            end
                        end else begin
                            n_len = '0;
                            n_phase = PH_SIZE;
                        end
                    end
                end
                PH_RSIZE: begin
                    n_pos = pos_inc;
                    if (pos_inc == 32'd4) begin
                        n_pos = '0;
                        n_phase = PH_WAVE;
                    end
                end
                PH_SIZE: begin
                    n_len = {i_data_byte, r_len[31:8]};
                    n_pos = pos_inc;
                    if (pos_inc == 32'd4) begin
                        n_pos = '0;
                        if (n_len == '0) begin
                            w_res[w_push[0]] = f_error(ERR_INVALID);
                            w_push = w_push + 2'd1;
                            n_phase = PH_WAIT;
                        end else if (r_tag == TAG_FMT) begin
                            if (n_len < FMT_MIN_LEN) begin
                                w_res[w_push[0]] = f_error(ERR_INVALID);
                                w_push = w_push + 2'd1;
                                n_phase = PH_WAIT;
                            end else begin
                                n_fmt = '0;
                                n_phase = PH_FMT;
                            end
                        end else if (r_tag == TAG_DATA) begin
                            n_dsize = n_len;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    n_fmt[{r_pos[3:0], 3'b000} +: 8] = i_data_byte;
                    n_pos = pos_inc;
                    if (pos_inc == FMT_MIN_LEN) begin
                        n_pos = '0;
                        if (r_len > FMT_MIN_LEN) begin
                            n_phase = PH_EXT;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_pos = pos_inc;
                    if (r_pos + 32'd17 == r_len) begin
                        fin = 1'b1;
                    end
                end
                PH_DATA: begin
                    last = (pos_inc == r_len);
                    w_res[w_push[0]] = f_payload(i_data_byte, last);
                    w_push = w_push + 2'd1;
                    n_pos = pos_inc;
                    if (last) begin
                        n_pos = '0;
                        n_dseen = 1'b1;
                        if (r_fseen) begin
                            w_res[w_push[0]] = f_format(EV_DONE, n_fmt, n_dsize);
                            w_push = w_push + 2'd1;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_ID;
                        end
                    end
                end
                PH_SKIP: begin
                    n_pos = pos_inc;
                    if (pos_inc == r_len) begin
                        n_pos = '0;
                        n_phase = PH_ID;
                    end
                end
                PH_WAIT: begin
                end
                default: begin
                end
            endcase

            // fmt chunk and its extension fully read
            if (fin) begin
                n_pos = '0;
                if (n_fmt[15:0] != FMT_PCM) begin
                    w_res[w_push[0]] = f_error(ERR_UNSUPPORTED);
                    w_push = w_push + 2'd1;
                    n_phase = PH_WAIT;
                end else begin
                    n_fseen = 1'b1;
                    w_res[w_push[0]] = f_format(EV_FORMAT, n_fmt, '0);
                    w_push = w_push + 2'd1;
                    if (r_dseen) begin
                        w_res[w_push[0]] = f_format(EV_DONE, n_fmt, n_dsize);
                        w_push = w_push + 2'd1;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_ID;
                    end
                end
            end

            // end of file: report an early end unless parsing already finished, then restart
            if (i_end_of_stream) begin
                if (n_phase != PH_WAIT) begin
                    w_res[w_push[0]] = f_error((n_phase == PH_DATA) ? ERR_TRUNCATED
                                                                    : ERR_INVALID);
                    w_push = w_push + 2'd1;
                end
                n_phase = PH_RIFF;
                n_pos   = '0;
                n_tag   = '0;
                n_len   = '0;
                n_fmt   = '0;
                n_dsize = '0;
                n_fseen = 1'b0;
                n_dseen = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_pos   <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_fmt   <= '0;
            r_dsize <= '0;
            r_fseen <= 1'b0;
            r_dseen <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_fmt   <= n_fmt;
            r_dsize <= n_dsize;
            r_fseen <= n_fseen;
            r_dseen <= n_dseen;
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_q[r_wr] <= w_res[0];
        end
        if (w_push == 2'd2) begin
            r_q[r_wr + Q_AW'(1)] <= w_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + Q_AW'(w_push);
            r_rd  <= r_rd + Q_AW'(w_pop);
            r_cnt <= r_cnt + Q_CW'(w_push) - Q_CW'(w_pop);
        end
    end

    assign o_event_res     = w_head.event_res;
    assign o_payload_byte  = w_head.payload_byte;
    assign o_last_payload  = w_head.last_payload;
    assign o_fmt_code      = w_head.fmt_code;
    assign o_chan_count    = w_head.chan_count;
    assign o_samp_rate     = w_head.samp_rate;
    assign o_bytes_per_sec = w_head.bytes_per_sec;
    assign o_frame_bytes   = w_head.frame_bytes;
    assign o_sample_bits   = w_head.sample_bits;
    assign o_payload_len   = w_head.payload_len;
    assign o_error_code    = w_head.error_code;

    `WCSP_ASSERT_ALWAYS(a_queue_bound, r_cnt <= Q_CW'(Q_DEPTH))
    `WCSP_ASSERT_IMPL(a_header_pos,
        r_phase == PH_RIFF || r_phase == PH_RSIZE || r_phase == PH_WAVE ||
        r_phase == PH_ID || r_phase == PH_SIZE, r_pos < 32'd4)
    `WCSP_ASSERT_IMPL(a_fmt_pos, r_phase == PH_FMT, r_pos < FMT_MIN_LEN)
    `WCSP_ASSERT_IMPL(a_wait_pos, r_phase == PH_WAIT, r_pos == '0)

endmodule

/* test/tb_wav_chunk_stream_parser.sv */
// testbench for the wav chunk stream parser: byte-level wav files against a predictor
`timescale 1ns / 1ps

module tb_wav_chunk_stream_parser;
    import wcsp_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_stream = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_res;
    logic [7:0]  o_payload_byte;
    logic        o_last_payload;
    logic [15:0] o_fmt_code;
    logic [15:0] o_chan_count;
    logic [31:0] o_samp_rate;
    logic [31:0] o_bytes_per_sec;
    logic [15:0] o_frame_bytes;
    logic [15:0] o_sample_bits;
    logic [31:0] o_payload_len;
    logic [1:0]  o_error_code;

    wav_chunk_stream_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_res     (o_event_res),
        .o_payload_byte  (o_payload_byte),
        .o_last_payload  (o_last_payload),
        .o_fmt_code      (o_fmt_code),
        .o_chan_count    (o_chan_count),
        .o_samp_rate     (o_samp_rate),
        .o_bytes_per_sec (o_bytes_per_sec),
        .o_frame_bytes   (o_frame_bytes),
        .o_sample_bits   (o_sample_bits),
        .o_payload_len   (o_payload_len),
        .o_error_code    (o_error_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_result      pending_events[$];
    t_result      oldest_event;
    logic [7:0]   file_bytes[$];
    int           failures = 0;
    int           bytes_sent = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_left = 0;

    // parser state as the predictor sees it
    t_phase       mdl_phase;
    logic [31:0]  mdl_pos;
    logic [31:0]  mdl_tag;
    logic [31:0]  mdl_len;
    logic [31:0]  mdl_data_len;
    logic [127:0] mdl_fmt;
    logic         mdl_fmt_seen;
    logic         mdl_data_seen;

    function automatic void model_reset();
        mdl_phase = PH_RIFF;
        mdl_pos = '0;
        mdl_tag = '0;
        mdl_len = '0;
        mdl_data_len = '0;
        mdl_fmt = '0;
        mdl_fmt_seen = 1'b0;
        mdl_data_seen = 1'b0;
    endfunction

    function automatic void emit_error(t_err code);
        t_result r;
        r = '0;
        r.event_res = EV_ERROR;
        r.error_code = code;
        pending_events.push_back(r);
        mdl_phase = PH_WAIT;
    endfunction

    function automatic void emit_format(t_event ev);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.fmt_code = mdl_fmt[15:0];
        r.chan_count = mdl_fmt[31:16];
        r.samp_rate = mdl_fmt[63:32];
        r.bytes_per_sec = mdl_fmt[95:64];
        r.frame_bytes = mdl_fmt[111:96];
        r.sample_bits = mdl_fmt[127:112];
        if (ev == EV_DONE) begin
            r.payload_len = mdl_data_len;
            mdl_phase = PH_WAIT;
        end
        pending_events.push_back(r);
    endfunction

    function automatic void close_fmt_chunk();
        mdl_pos = '0;
        if (mdl_fmt[15:0] != FMT_PCM) begin
            emit_error(ERR_UNSUPPORTED);
        end else begin
            mdl_fmt_seen = 1'b1;
            emit_format(EV_FORMAT);
            if (mdl_data_seen) begin
                emit_format(EV_DONE);
            end else begin
                mdl_phase = PH_ID;
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eos);
        t_result r;
        logic    chunk_done;
        case (mdl_phase)
            PH_RIFF, PH_WAVE, PH_ID: begin
                mdl_tag = {b, mdl_tag[31:8]};
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == 32'd4) begin
                    mdl_pos = '0;
                    if (mdl_phase == PH_RIFF) begin
                        if (mdl_tag != TAG_RIFF) emit_error(ERR_INVALID);
                        else mdl_phase = PH_RSIZE;
                    end else if (mdl_phase == PH_WAVE) begin
                        if (mdl_tag != TAG_WAVE) emit_error(ERR_INVALID);
                        else mdl_phase = PH_ID;
                    end else begin
                        mdl_len = '0;
                        mdl_phase = PH_SIZE;
                    end
                end
            end
            PH_RSIZE: begin
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == 32'd4) begin
                    mdl_pos = '0;
                    mdl_phase = PH_WAVE;
                end
            end
            PH_SIZE: begin
                mdl_len = {b, mdl_len[31:8]};
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == 32'd4) begin
                    mdl_pos = '0;
                    if (mdl_len == '0) begin
                        emit_error(ERR_INVALID);
                    end else if (mdl_tag == TAG_FMT) begin
                        if (mdl_len < FMT_MIN_LEN) begin
                            emit_error(ERR_INVALID);
                        end else begin
                            mdl_fmt = '0;
                            mdl_phase = PH_FMT;
                        end
                    end else if (mdl_tag == TAG_DATA) begin
                        mdl_data_len = mdl_len;
                        mdl_phase = PH_DATA;
                    end else begin
                        mdl_phase = PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                mdl_fmt[{mdl_pos[3:0], 3'b000} +: 8] = b;
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == FMT_MIN_LEN) begin
                    mdl_pos = '0;
                    if (mdl_len > FMT_MIN_LEN) mdl_phase = PH_EXT;
                    else close_fmt_chunk();
                end
            end
            PH_EXT: begin
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == mdl_len - FMT_MIN_LEN) close_fmt_chunk();
            end
            PH_DATA: begin
                r = '0;
                r.event_res = EV_PAYLOAD;
                r.payload_byte = b;
                mdl_pos = mdl_pos + 32'd1;
                chunk_done = (mdl_pos == mdl_len);
                r.last_payload = chunk_done;
                pending_events.push_back(r);
                if (chunk_done) begin
                    mdl_pos = '0;
                    mdl_data_seen = 1'b1;
                    if (mdl_fmt_seen) emit_format(EV_DONE);
                    else mdl_phase = PH_ID;
                end
            end
            PH_SKIP: begin
                mdl_pos = mdl_pos + 32'd1;
                if (mdl_pos == mdl_len) begin
                    mdl_pos = '0;
                    mdl_phase = PH_ID;
                end
            end
            default: begin
            end
        endcase
        if (eos) begin
            if (mdl_phase != PH_WAIT) begin
                emit_error(mdl_phase == PH_DATA ? ERR_TRUNCATED : ERR_INVALID);
            end
            model_reset();
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // byte transfers feed the predictor, result transfers are checked in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_byte(i_data_byte, i_end_of_stream);
            if (o_valid && !i_stall) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected result transfer, event_res %0d", o_event_res);
                    failures++;
                end else begin
                    oldest_event = pending_events.pop_front();
                    check_field("event_res", oldest_event.event_res, o_event_res);
                    check_field("payload_byte", oldest_event.payload_byte, o_payload_byte);
                    check_field("last_payload", oldest_event.last_payload, o_last_payload);
                    check_field("fmt_code", oldest_event.fmt_code, o_fmt_code);
                    check_field("chan_count", oldest_event.chan_count, o_chan_count);
                    check_field("samp_rate", oldest_event.samp_rate, o_samp_rate);
                    check_field("bytes_per_sec", oldest_event.bytes_per_sec,
                                o_bytes_per_sec);
                    check_field("frame_bytes", oldest_event.frame_bytes, o_frame_bytes);
                    check_field("sample_bits", oldest_event.sample_bits, o_sample_bits);
                    check_field("payload_len", oldest_event.payload_len, o_payload_len);
                    check_field("error_code", oldest_event.error_code, o_error_code);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void put_u8(logic [7:0] v);
        file_bytes.push_back(v);
    endfunction

    function automatic void put_u16(logic [15:0] v);
        put_u8(v[7:0]);
        put_u8(v[15:8]);
    endfunction

    function automatic void put_u32(logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endfunction

    function automatic void put_header();
        put_u32(TAG_RIFF);
        put_u32($urandom);
        put_u32(TAG_WAVE);
    endfunction

    function automatic void put_fmt(logic [15:0] code, logic [15:0] chans, logic [31:0] rate,
                                    logic [31:0] brate, logic [15:0] align,
                                    logic [15:0] bits, int ext_len);
        put_u32(TAG_FMT);
        put_u32(FMT_MIN_LEN + ext_len);
        put_u16(code);
        put_u16(chans);
        put_u32(rate);
        put_u32(brate);
        put_u16(align);
        put_u16(bits);
        for (int i = 0; i < ext_len; i++) put_u8(8'($urandom));
    endfunction

    function automatic void put_random_fmt(logic [15:0] code, int ext_len);
        put_fmt(code, 16'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom), ext_len);
    endfunction

    function automatic void put_data(int len);
        put_u32(TAG_DATA);
        put_u32(len);
        for (int i = 0; i < len; i++) put_u8(8'($urandom));
    endfunction

    function automatic void put_skip(int len);
        logic [31:0] id;
        id = $urandom;
        if (id == TAG_FMT || id == TAG_DATA) id = ~id;
        put_u32(id);
        put_u32(len);
        for (int i = 0; i < len; i++) put_u8(8'($urandom));
    endfunction

    function automatic void cut_file(int keep);
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    endfunction

    function automatic void build_random_wav();
        logic        data_first;
        int          first_copies;
        logic [15:0] code;
        data_first = 1'($urandom);
        first_copies = ($urandom_range(99) < 20) ? 2 : 1;
        code = ($urandom_range(99) < 10) ? 16'($urandom) : FMT_PCM;
        put_header();
        for (int n = 0; n < first_copies + 1; n++) begin
            if ($urandom_range(99) < 25) put_skip($urandom_range(1, 8));
            if ((n < first_copies) == data_first) put_data($urandom_range(1, 24));
            else put_random_fmt(code, ($urandom_range(1) == 1) ? $urandom_range(1, 4) : 0);
        end
        for (int i = $urandom_range(3); i > 0; i--) put_u8(8'($urandom));
    endfunction

    task automatic send_byte(logic [7:0] b, logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_pcm_file_extremes();
        put_header();
        put_fmt(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
        put_u32(TAG_DATA);
        put_u32(32'd1);
        put_u8(8'hFF);
        send_file();
        put_header();
        put_fmt(FMT_PCM, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 0);
        put_u32(TAG_DATA);
        put_u32(32'd2);
        put_u8(8'h00);
        put_u8(8'hA5);
        send_file();
        wait_results_drained();
    endtask

    task automatic test_data_before_fmt();
        put_header();
        put_skip(3);
        put_data(2);
        put_fmt(FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16, 2);
        put_u8(8'h5A);
        put_u8(8'hC3);
        send_file();
        wait_results_drained();
    endtask

    task automatic test_bad_magic();
        put_u32({"X", "F", "I", "R"});
        put_u8(8'h00);
        put_u8(8'hFF);
        send_file();
        put_u32(TAG_RIFF);
        put_u32(32'd36);
        put_u32({"X", "V", "A", "W"});
        send_file();
        wait_results_drained();
    endtask

    task automatic test_bad_sizes();
        put_header();
        put_u32({"T", "S", "I", "L"});
        put_u32(32'd0);
        put_u8(8'h11);
        send_file();
        put_header();
        put_u32(TAG_FMT);
        put_u32(FMT_MIN_LEN - 1);
        send_file();
        wait_results_drained();
    endtask

    task automatic test_non_pcm_format();
        put_header();
        put_fmt(16'd3, 16'd1, 32'd48000, 32'd192000, 16'd4, 16'd32, 2);
        put_data(1);
        send_file();
        wait_results_drained();
    endtask

    task automatic test_repeated_chunks();
        put_header();
        put_random_fmt(FMT_PCM, 0);
        put_random_fmt(FMT_PCM, 1);
        put_data(2);
        send_file();
        put_header();
        put_data(1);
        put_data(3);
        put_random_fmt(FMT_PCM, 0);
        send_file();
        wait_results_drained();
    endtask

    task automatic test_early_end();
        put_header();
        put_random_fmt(FMT_PCM, 0);
        put_data(8);
        cut_file(file_bytes.size() - 3);
        send_file();
        put_header();
        put_random_fmt(FMT_PCM, 0);
        cut_file(25);
        send_file();
        put_header();
        put_u32(TAG_DATA);
        put_u16(16'h0010);
        send_file();
        put_u8("R");
        send_file();
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct = 0;
        put_header();
        put_random_fmt(FMT_PCM, 0);
        put_data(40);
        hold_left = 24 * Q_DEPTH;
        send_file();
        wait_results_drained();
    endtask

    task automatic test_random_files(int idle_pct, int stall_pct, int n_bytes);
        int start;
        int kind;
        send_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                for (int i = $urandom_range(1, 16); i > 0; i--) put_u8(8'($urandom));
            end else begin
                build_random_wav();
                if (kind < 22) begin
                    cut_file($urandom_range(1, file_bytes.size() - 1));
                end else if (kind < 32) begin
                    kind = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes[kind] = file_bytes[kind] ^ 8'($urandom_range(1, 255));
                end
            end
            send_file();
        end
        wait_results_drained();
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pcm_file_extremes();
        test_data_before_fmt();
        test_bad_magic();
        test_bad_sizes();
        test_non_pcm_format();
        test_repeated_chunks();
        test_early_end();
        test_output_backpressure();
        test_random_files(0, 0, ITEM_TARGET / 8);
        test_random_files(81, 0, ITEM_TARGET / 8);
        test_random_files(0, 81, ITEM_TARGET / 8);
        test_random_files(16, 16, ITEM_TARGET / 8);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_events.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/wcsp_pkg.sv
hdl/wav_chunk_stream_parser.sv
test/tb_wav_chunk_stream_parser.sv
